### hdl/sxkz_pkg.sv
// Shared types, letter codes and classification functions for the Kazakh Soundex coder.
`default_nettype none

package sxkz_pkg;

  localparam int unsigned LetterW = 11;
  localparam int unsigned ClassW  = 4;
  localparam int unsigned CodeW   = 24;
  localparam int unsigned FieldDigits = 8;

  localparam logic [LetterW-1:0] CpDeUp  = 11'h414;
  localparam logic [LetterW-1:0] CpZheLo = 11'h436;
  localparam logic [LetterW-1:0] CpZheUp = 11'h416;
  localparam logic [LetterW-1:0] CpLowA  = 11'h430;

  localparam logic [ClassW-1:0] NoClass  = 4'd8;
  localparam logic [ClassW-1:0] ClassDe  = 4'd3;
  localparam logic [ClassW-1:0] ClassVow = 4'd0;

  // configuration register indexes
  localparam logic CfgCodeLength = 1'b0;
  localparam logic CfgDzhEnable  = 1'b1;

  localparam logic [ClassW-1:0] BasicClass [32] = '{
    4'd0, 4'd1, 4'd1, 4'd4, 4'd3, 4'd0, 4'd2, 4'd2,
    4'd0, 4'd0, 4'd4, 4'd7, 4'd5, 4'd5, 4'd0, 4'd1,
    4'd6, 4'd2, 4'd3, 4'd0, 4'd1, 4'd4, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // classified word passed from front to back
  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               last;
    logic [ClassW-1:0]  cls;       // class of the letter as it stands
    logic [ClassW-1:0]  head_cls;  // class of its lowercase form
    logic               is_de_up;
    logic               is_zhe_lo;
  } cls_item_t;

  typedef struct packed {
    logic [LetterW-1:0] head;
    logic [CodeW-1:0]   digits;
  } out_item_t;

  function automatic logic [ClassW-1:0] class_of(input logic [LetterW-1:0] c);
    logic [LetterW-1:0] off;
    logic [ClassW-1:0]  k;
    off = c - CpLowA;
    if (c >= 11'h430 && c <= 11'h44F) begin
      k = BasicClass[off[4:0]];
    end else begin
      unique case (c)
        11'h451, 11'h456, 11'h4D9, 11'h4E9, 11'h4B1, 11'h4AF: k = 4'd0;
        11'h49B, 11'h493, 11'h4BB:                           k = 4'd4;
        11'h4A3:                                             k = 4'd5;
        default:                                             k = NoClass;
      endcase
    end
    return k;
  endfunction

  function automatic logic [LetterW-1:0] lower_of(input logic [LetterW-1:0] c);
    logic [LetterW-1:0] l;
    if (c >= 11'h410 && c <= 11'h42F) begin
      l = c + 11'h020;
    end else if (c >= 11'h400 && c <= 11'h40F) begin
      l = c + 11'h050;
    end else if (c >= 11'h460 && c <= 11'h4FF && !c[0]) begin
      l = c + 11'h001;
    end else begin
      l = c;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

### hdl/soundex_code_kazakh_cyrillic_unit.sv
// Top level of the Kazakh Cyrillic Soundex coder: config registers, front, queues, back.
`default_nettype none

// Channel   | Handshake              | Word
// ----------+------------------------+--------------------------------------------
// letters   | push / full            | letter_i[10:0], last_letter_i
// results   | empty / pop            | head_letter_o[10:0], code_digits_o[23:0]
// config    | cfg_we_i (no stall)    | cfg_idx_i (0 code_length, 1 dzh rule), cfg_data_i[3:0]
//
// One letter a cycle sustained while the result queue has room; run collapse and digit
// packing in the back end are combinational. A last letter is coded by the back end as it
// leaves the letter queue; its result is pushed into the result queue and popped from there.
// Reset (rst_ni low, async) empties both queues, clears word state and loads
// code_length 5 and dzh rule on. A full result queue stalls the back end; the
// letter queue then fills and raises full. No clearing pass is needed.

module soundex_code_kazakh_cyrillic_unit
  import sxkz_pkg::*;
#(
  parameter int unsigned MAX_CODE_DIGITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // letter words
  input  wire logic               push,
  output logic                    full,
  input  wire logic [LetterW-1:0] letter_i,
  input  wire logic               last_letter_i,
  // result words
  output logic                    empty,
  input  wire logic               pop,
  output logic      [LetterW-1:0] head_letter_o,
  output logic      [CodeW-1:0]   code_digits_o,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [3:0]         cfg_data_i
);

  logic [3:0] code_length_q;
  logic       dzh_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= 4'd5;
      dzh_en_q      <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCodeLength: code_length_q <= cfg_data_i;
        CfgDzhEnable:  dzh_en_q      <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  cls_item_t front_item, back_item;
  logic      mid_empty, mid_pop;
  out_item_t res_in, res_out;
  logic      res_full, res_push;

  // front: classify and queue
  sxkz_front u_front (
    .letter_i (letter_i),
    .last_i   (last_letter_i),
    .item_o   (front_item)
  );

  sxkz_fifo #(
    .Width ($bits(cls_item_t))
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (back_item),
    .empty_o (mid_empty)
  );

  // back: coding state and result assembly
  sxkz_back #(
    .MaxCodeDigits (MAX_CODE_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .code_length_i (code_length_q),
    .dzh_en_i      (dzh_en_q),
    .item_i        (back_item),
    .item_empty_i  (mid_empty),
    .item_pop_o    (mid_pop),
    .out_full_i    (res_full),
    .out_push_o    (res_push),
    .out_o         (res_in)
  );

  // result queue parts the back end from the consumer
  sxkz_fifo #(
    .Width ($bits(out_item_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign head_letter_o = res_out.head;
  assign code_digits_o = res_out.digits;

endmodule

`default_nettype wire

### hdl/sxkz_fifo.sv
// Two-entry word queue with registered storage.
`default_nettype none

module sxkz_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/sxkz_front.sv
// Front end: classifies each incoming letter for the coding back end.
`default_nettype none

module sxkz_front
  import sxkz_pkg::*;
(
  input  wire logic [LetterW-1:0] letter_i,
  input  wire logic               last_i,
  output cls_item_t               item_o
);

  always_comb begin
    item_o.letter    = letter_i;
    item_o.last      = last_i;
    item_o.cls       = class_of(letter_i);
    item_o.head_cls  = class_of(lower_of(letter_i));
    item_o.is_de_up  = (letter_i == CpDeUp);
    item_o.is_zhe_lo = (letter_i == CpZheLo);
  end

endmodule

`default_nettype wire

### hdl/sxkz_back.sv
// Back end: head tracking, run collapse, digit packing and result assembly.
`default_nettype none

module sxkz_back
  import sxkz_pkg::*;
#(
  parameter int unsigned MaxCodeDigits = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [3:0]  code_length_i,
  input  wire logic        dzh_en_i,
  input  wire cls_item_t   item_i,
  input  wire logic        item_empty_i,
  output logic             item_pop_o,
  input  wire logic        out_full_i,
  output logic             out_push_o,
  output out_item_t        out_o
);

  // digits past the kept limit can never reach the output
  localparam int unsigned Keep = (MaxCodeDigits < FieldDigits) ? MaxCodeDigits : FieldDigits;
  localparam int unsigned CntW = $clog2(Keep + 1);
  localparam int unsigned BufW = 3 * Keep;

  logic               in_word_q, in_word_d;
  logic               pending_q, pending_d;
  logic [LetterW-1:0] head_q, head_d;
  logic [ClassW-1:0]  last_cls_q, last_cls_d;
  logic [BufW-1:0]    buf_q, buf_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic               take;
  logic               add;
  logic               hold;
  logic [ClassW-1:0]  seed;
  logic [BufW-1:0]    buf_w;
  logic [CntW-1:0]    cnt_w;
  logic [ClassW-1:0]  cls_w;
  logic [3:0]         len;
  logic [CodeW-1:0]   buf_ext;
  logic [CodeW-1:0]   digits;

  assign take       = !item_empty_i && !out_full_i;
  assign item_pop_o = take;
  assign out_push_o = take && item_i.last;

  always_comb begin
    hold       = 1'b0;
    add        = 1'b1;
    seed       = last_cls_q;
    buf_w      = buf_q;
    cnt_w      = cnt_q;
    head_d     = head_q;
    pending_d  = pending_q;
    in_word_d  = in_word_q;
    if (!in_word_q) begin
      buf_w = '0;
      cnt_w = '0;
      if (pending_q) begin
        pending_d = 1'b0;
        in_word_d = 1'b1;
        if (item_i.is_zhe_lo) begin
          head_d = CpZheLo;
          seed   = item_i.head_cls;
          add    = 1'b0;
        end else begin
          head_d = CpDeUp;
          seed   = ClassDe;
        end
      end else if (dzh_en_i && item_i.is_de_up && !item_i.last) begin
        hold      = 1'b1;
        pending_d = 1'b1;
        add       = 1'b0;
      end else begin
        in_word_d = 1'b1;
        head_d    = item_i.letter;
        seed      = item_i.head_cls;
        add       = 1'b0;
      end
    end

    cls_w = seed;
    if (add && item_i.cls != NoClass && item_i.cls != seed) begin
      cls_w = item_i.cls;
      if (item_i.cls != ClassVow && cnt_w < CntW'(Keep)) begin
        for (int j = 0; j < Keep; j++) begin
          if (cnt_w == CntW'(j)) begin
            buf_w[3*j +: 3] = item_i.cls[2:0];
          end
        end
        cnt_w = cnt_w + CntW'(1);
      end
    end

    last_cls_d = hold ? last_cls_q : cls_w;
    buf_d      = buf_w;
    cnt_d      = cnt_w;
    if (item_i.last) begin
      in_word_d  = 1'b0;
      pending_d  = 1'b0;
      head_d     = '0;
      last_cls_d = NoClass;
      buf_d      = '0;
      cnt_d      = '0;
    end
  end

  // result assembly, clamping the digit count to the kept range
  always_comb begin
    if (code_length_i == 4'd0) begin
      len = 4'd1;
    end else if (code_length_i > 4'(Keep)) begin
      len = 4'(Keep);
    end else begin
      len = code_length_i;
    end
    buf_ext = CodeW'(buf_w);
    digits  = '0;
    for (int j = 0; j < FieldDigits; j++) begin
      if (4'(j) < len) begin
        digits[3*j +: 3] = buf_ext[3*j +: 3];
      end
    end
    out_o.digits = digits;
    if (!in_word_q && !pending_q) begin
      out_o.head = (item_i.letter == CpZheLo) ? CpZheUp : item_i.letter;
    end else if (!in_word_q) begin
      out_o.head = item_i.is_zhe_lo ? CpZheUp : CpDeUp;
    end else begin
      out_o.head = (head_q == CpZheLo) ? CpZheUp : head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q  <= 1'b0;
      pending_q  <= 1'b0;
      head_q     <= '0;
      last_cls_q <= NoClass;
      buf_q      <= '0;
      cnt_q      <= '0;
    end else if (take) begin
      in_word_q  <= in_word_d;
      pending_q  <= pending_d;
      head_q     <= head_d;
      last_cls_q <= last_cls_d;
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### tb/soundex_code_checker.sv
// Watches the letter, result and register channels of the Soundex coder and checks every result.
`timescale 1ns / 100ps

module soundex_code_checker
  import sxkz_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [LetterW-1:0] letter_i,
  input  logic               last_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [LetterW-1:0] head_i,
  input  logic [CodeW-1:0]   digits_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  output int                 backlog_o,
  output int                 mismatches_o
);

  out_item_t codes_due [$];
  int        mismatches = 0;

  // predicted coder state
  logic               in_name    = 1'b0;
  logic [LetterW-1:0] head       = '0;
  logic               de_held    = 1'b0;
  logic [ClassW-1:0]  prev_class = NoClass;
  logic [CodeW-1:0]   digits     = '0;
  int unsigned        ndigits    = 0;
  logic [3:0]         code_len   = 4'd5;
  logic               dzh_on     = 1'b1;

  assign mismatches_o = mismatches;
  initial backlog_o = 0;

  function automatic logic [ClassW-1:0] kz_class(input logic [LetterW-1:0] c);
    case (c)
      11'h430, 11'h435, 11'h438, 11'h439, 11'h43E, 11'h443,
      11'h44A, 11'h44B, 11'h44C, 11'h44D, 11'h44E, 11'h44F,
      11'h451, 11'h456, 11'h4D9, 11'h4E9, 11'h4B1, 11'h4AF: return 4'd0;
      11'h431, 11'h432, 11'h43F, 11'h444:                   return 4'd1;
      11'h436, 11'h437, 11'h441, 11'h446, 11'h447,
      11'h448, 11'h449:                                     return 4'd2;
      11'h434, 11'h442:                                     return 4'd3;
      11'h433, 11'h43A, 11'h445, 11'h49B, 11'h493, 11'h4BB: return 4'd4;
      11'h43C, 11'h43D, 11'h4A3:                            return 4'd5;
      11'h440:                                              return 4'd6;
      11'h43B:                                              return 4'd7;
      default:                                              return NoClass;
    endcase
  endfunction

  // lowercase form; only the head letter is folded
  function automatic logic [LetterW-1:0] fold_case(input logic [LetterW-1:0] c);
    if (c >= 11'h410 && c <= 11'h42F) return c + 11'h020;
    if (c >= 11'h400 && c <= 11'h40F) return c + 11'h050;
    if (c >= 11'h460 && c <= 11'h4FF && !c[0]) return c + 11'h001;
    return c;
  endfunction

  task automatic open_name(input logic [LetterW-1:0] c);
    in_name    = 1'b1;
    head       = c;
    prev_class = kz_class(fold_case(c));
    digits     = '0;
    ndigits    = 0;
  endtask

  // run collapse: zero classes break a run but leave no digit
  task automatic code_letter(input logic [LetterW-1:0] c);
    logic [ClassW-1:0] k;
    k = kz_class(c);
    if (k != NoClass && k != prev_class) begin
      if (k != 4'd0 && ndigits < FieldDigits) begin
        digits[3*ndigits +: 3] = k[2:0];
        ndigits++;
      end
      prev_class = k;
    end
  endtask

  task automatic flag(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned kept;
    logic [31:0] mask;
    out_item_t   want;
    if (!rst_ni) begin
      codes_due.delete();
      in_name    = 1'b0;
      head       = '0;
      de_held    = 1'b0;
      prev_class = NoClass;
      digits     = '0;
      ndigits    = 0;
      code_len   = 4'd5;
      dzh_on     = 1'b1;
      backlog_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgCodeLength) code_len = cfg_data_i;
        else                            dzh_on   = cfg_data_i[0];
      end

      if (pop_i && !empty_i) begin
        if (codes_due.size() == 0) begin
          flag($sformatf("result head %h digits %h with nothing due", head_i, digits_i));
        end else begin
          want = codes_due.pop_front();
          if (head_i !== want.head)
            flag($sformatf("head_letter %h, expected %h", head_i, want.head));
          if (digits_i !== want.digits)
            flag($sformatf("code_digits %h, expected %h", digits_i, want.digits));
        end
      end

      if (push_i && !full_i) begin
        if (!in_name) begin
          if (de_held) begin
            de_held = 1'b0;
            if (letter_i == CpZheLo) begin
              open_name(CpZheLo);
            end else begin
              open_name(CpDeUp);
              code_letter(letter_i);
            end
          end else if (dzh_on && letter_i == CpDeUp && !last_i) begin
            de_held = 1'b1;
          end else begin
            open_name(letter_i);
          end
        end else begin
          code_letter(letter_i);
        end

        if (last_i) begin
          kept = (code_len == 0) ? 1 : code_len;
          if (kept > MAX_DIGITS) kept = MAX_DIGITS;
          if (kept > FieldDigits) kept = FieldDigits;
          mask        = (32'd1 << (3 * kept)) - 32'd1;
          want.head   = (head == CpZheLo) ? CpZheUp : head;
          want.digits = digits & mask[CodeW-1:0];
          codes_due.push_back(want);
          in_name    = 1'b0;
          head       = '0;
          de_held    = 1'b0;
          prev_class = NoClass;
          digits     = '0;
          ndigits    = 0;
        end
      end
      backlog_o <= codes_due.size();
    end
  end

endmodule

### tb/tb_soundex_code_kazakh_cyrillic_unit.sv
// Testbench top: stimulus, result draining and verdict for the Kazakh Cyrillic Soundex coder.
`timescale 1ns / 100ps

module tb_soundex_code_kazakh_cyrillic_unit;
  import sxkz_pkg::*;

  localparam int unsigned MaxDigits  = 8;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Settle     = 16;     // drain time after the last result
  localparam int unsigned PhaseSize  = 240;    // letters per register setting

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push   = 1'b0;
  logic               full;
  logic [LetterW-1:0] letter_i      = '0;
  logic               last_letter_i = 1'b0;
  logic               empty;
  logic               pop    = 1'b0;
  logic [LetterW-1:0] head_letter_o;
  logic [CodeW-1:0]   code_digits_o;
  logic               cfg_we_i   = 1'b0;
  logic               cfg_idx_i  = CfgCodeLength;
  logic [3:0]         cfg_data_i = '0;

  int          backlog;
  int          mismatches;
  int unsigned cycles = 0;
  logic        push_burst = 1'b0;  // no gaps between letter words while set

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  soundex_code_kazakh_cyrillic_unit #(
    .MAX_CODE_DIGITS(MaxDigits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .letter_i     (letter_i),
    .last_letter_i(last_letter_i),
    .empty        (empty),
    .pop          (pop),
    .head_letter_o(head_letter_o),
    .code_digits_o(code_digits_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  soundex_code_checker #(
    .MAX_DIGITS(MaxDigits)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .letter_i    (letter_i),
    .last_i      (last_letter_i),
    .empty_i     (empty),
    .pop_i       (pop),
    .head_i      (head_letter_o),
    .digits_i    (code_digits_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .backlog_o   (backlog),
    .mismatches_o(mismatches)
  );

  // Kazakh letters outside the basic block: lowercase forms, then their capitals
  localparam logic [LetterW-1:0] KzLower [10] = '{
    11'h451, 11'h456, 11'h4D9, 11'h4E9, 11'h4B1, 11'h4AF, 11'h49B, 11'h493, 11'h4BB, 11'h4A3
  };
  localparam logic [LetterW-1:0] KzUpper [10] = '{
    11'h401, 11'h406, 11'h4D8, 11'h4E8, 11'h4B0, 11'h4AE, 11'h49A, 11'h492, 11'h4BA, 11'h4A2
  };

  // Directed names, {last, letter}:
  //  lone capital DE (never held), DE+zhe pair, DE before lowercase de (shared class),
  //  capital head whose class swallows the next letter, unmapped head with a capital
  //  skipped inside, and a long name that overflows the eight digit slots.
  localparam logic [LetterW:0] Warmup [25] = '{
    {1'b1, 11'h414},
    {1'b0, 11'h414}, {1'b0, 11'h436}, {1'b0, 11'h430}, {1'b1, 11'h43B},
    {1'b0, 11'h414}, {1'b0, 11'h434}, {1'b1, 11'h43C},
    {1'b0, 11'h411}, {1'b0, 11'h431}, {1'b1, 11'h440},
    {1'b0, 11'h000}, {1'b0, 11'h41C}, {1'b1, 11'h4A3},
    {1'b0, 11'h430}, {1'b0, 11'h431}, {1'b0, 11'h441}, {1'b0, 11'h434}, {1'b0, 11'h43A},
    {1'b0, 11'h43C}, {1'b0, 11'h440}, {1'b0, 11'h43B}, {1'b0, 11'h431}, {1'b0, 11'h441},
    {1'b1, 11'h4FF}
  };

  // Letter mix: mostly mapped lowercase, some capitals and raw code points,
  // and the DE / zhe pair sprinkled in mid-name too.
  function automatic logic [LetterW-1:0] draw_letter();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 8)  return CpLowA + LetterW'($urandom_range(0, 31));
    if (pick < 12) return KzLower[$urandom_range(0, 9)];
    if (pick < 13) return 11'h410 + LetterW'($urandom_range(0, 31));
    if (pick < 14) return KzUpper[$urandom_range(0, 9)];
    if (pick < 18) return LetterW'($urandom_range(0, 1279));
    if (pick < 19) return CpDeUp;
    return CpZheLo;
  endfunction

  // One letter word; the idle gap is drawn before the word is offered.
  // push is only lowered when a gap follows, so back-to-back words keep it high.
  task automatic put_letter(input logic [LetterW-1:0] l, input logic fin);
    int unsigned gap;
    gap = push_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    letter_i      <= l;
    last_letter_i <= fin;
    do @(posedge clk_i); while (full);
  endtask

  // A name of len letters; a third of them open on capital DE, usually followed by zhe.
  task automatic send_name(input int unsigned len);
    logic [LetterW-1:0] l;
    logic               de_head;
    de_head    = 1'b0;
    push_burst = ($urandom_range(0, 9) < 3);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(0, 2) == 0) begin
        l       = CpDeUp;
        de_head = 1'b1;
      end else if (i == 1 && de_head && $urandom_range(0, 4) < 3) begin
        l = CpZheLo;
      end else begin
        l = draw_letter();
      end
      put_letter(l, i == len - 1);
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: a stall drawn per result word, with occasional stall-free stretches.
  initial begin : result_drain
    int unsigned stall;
    logic        pop_burst;
    pop_burst = 1'b0;
    wait (rst_ni);
    forever begin
      stall = pop_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if ($urandom_range(0, 15) == 0) pop_burst = ~pop_burst;
    end
  end

  initial begin : stimulus
    logic [3:0]  len_setting [6];
    logic        dzh_setting [6];
    int unsigned sent;
    int unsigned len;
    // register extremes first, then a fixed length of three and one drawn setting
    len_setting = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'($urandom_range(0, 15))};
    dzh_setting = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1))};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed names under the reset settings (five digits, rule on)
    for (int i = 0; i < 25; i++) begin
      put_letter(Warmup[i][LetterW-1:0], Warmup[i][LetterW]);
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CfgCodeLength, len_setting[p]);
      write_reg(CfgDzhEnable, {3'b000, dzh_setting[p]});
      sent = 0;
      while (sent < PhaseSize) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 8);
        send_name(len);
        sent += len;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
